// ===== rtl/nsvl_pkg.sv =====
// Shared types and constants for the nearest-seed Voronoi label unit.
// No dependencies; the rtl files refer to it by scoped names, the dv files import it.
package nsvl_pkg;

  // Sizes
  localparam int MAX_SEEDS_DEF  = 256;
  localparam int MAX_IMAGES_DEF = 256;
  localparam int COORD_BITS     = 16;
  localparam int FIELD_W        = 16;              // coordinate field width on the bus
  localparam int SLOT_W         = 8;
  localparam int SRC_W          = 9;
  localparam int ID_W           = 10;
  localparam int CNT_W          = 9;               // seed_count / image_count registers
  localparam int DIFF_W         = COORD_BITS + 1;
  localparam int SQ_W           = 2 * COORD_BITS + 1;
  localparam int DIST_W         = SQ_W + 2;

  // Bus widths and field positions
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int SLOT_LSB = 0;
  localparam int X_LSB    = SLOT_LSB + SLOT_W;
  localparam int Y_LSB    = X_LSB + FIELD_W;
  localparam int Z_LSB    = Y_LSB + FIELD_W;
  localparam int SRC_LSB  = Z_LSB + FIELD_W;

  // Item kinds
  typedef enum logic [1:0] {
    OP_LOAD_PRIM = 2'd0,
    OP_LOAD_IMG  = 2'd1,
    OP_QUERY     = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SEED_COUNT  = 2'd0,
    REG_IMAGE_COUNT = 2'd1,
    REG_PERIODIC    = 2'd2
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_PRIM,
    ST_SCAN_IMG,
    ST_DRAIN,
    ST_MAP,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_prim;
    logic load_img;
    logic start;
    logic rd_prim;
    logic rd_img;
    logic rd_src;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/nsvl_ctrl.sv =====
// Controller for the nearest-seed label unit: item intake, seed scan sequencing.
// Depends on nsvl_pkg.
module nsvl_ctrl #(
  parameter int CW = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  nsvl_pkg::op_t        opcode,
  output logic                 s_tready,
  input  logic [CW-1:0]        ns,
  input  logic [CW-1:0]        ni,
  input  nsvl_pkg::status_t    status,
  output nsvl_pkg::cmd_t       cmd,
  output logic [CW-1:0]        scan_idx
);

  nsvl_pkg::state_t state, state_next;
  logic [CW-1:0]    scan_idx_next;
  logic             last_prim, last_img;

  assign last_prim = ((scan_idx + CW'(1)) == ns);
  assign last_img  = ((scan_idx + CW'(1)) == ni);

  // State register and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nsvl_pkg::ST_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nsvl_pkg::ST_IDLE: begin
        if (s_tvalid && (opcode == nsvl_pkg::OP_QUERY)) begin
          if (ns != '0)      state_next = nsvl_pkg::ST_SCAN_PRIM;
          else if (ni != '0) state_next = nsvl_pkg::ST_SCAN_IMG;
          else               state_next = nsvl_pkg::ST_DRAIN;
        end
      end
      nsvl_pkg::ST_SCAN_PRIM: begin
        if (last_prim) begin
          state_next = (ni != '0) ? nsvl_pkg::ST_SCAN_IMG : nsvl_pkg::ST_DRAIN;
        end
      end
      nsvl_pkg::ST_SCAN_IMG: begin
        if (last_img) state_next = nsvl_pkg::ST_DRAIN;
      end
      nsvl_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) state_next = nsvl_pkg::ST_MAP;
      end
      nsvl_pkg::ST_MAP: begin
        state_next = nsvl_pkg::ST_FINISH;
      end
      nsvl_pkg::ST_FINISH: begin
        if (status.out_free) state_next = nsvl_pkg::ST_IDLE;
      end
      default: state_next = nsvl_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, commands, counter
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    scan_idx_next = '0;
    case (state)
      nsvl_pkg::ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_prim = s_tvalid && (opcode == nsvl_pkg::OP_LOAD_PRIM);
        cmd.load_img  = s_tvalid && (opcode == nsvl_pkg::OP_LOAD_IMG);
        cmd.start     = s_tvalid && (opcode == nsvl_pkg::OP_QUERY);
      end
      nsvl_pkg::ST_SCAN_PRIM: begin
        cmd.rd_prim   = 1'b1;
        scan_idx_next = last_prim ? '0 : scan_idx + CW'(1);
      end
      nsvl_pkg::ST_SCAN_IMG: begin
        cmd.rd_img    = 1'b1;
        scan_idx_next = scan_idx + CW'(1);
      end
      nsvl_pkg::ST_MAP: begin
        cmd.rd_src = 1'b1;
      end
      nsvl_pkg::ST_FINISH: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/nsvl_datapath.sv =====
// Datapath for the nearest-seed label unit: config registers, seed stores,
// distance pipeline, running minimum and result register. Depends on nsvl_pkg.
module nsvl_datapath #(
  parameter int MAX_SEEDS  = nsvl_pkg::MAX_SEEDS_DEF,
  parameter int MAX_IMAGES = nsvl_pkg::MAX_IMAGES_DEF,
  parameter int CW         = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  nsvl_pkg::cmd_t                    cmd,
  output nsvl_pkg::status_t                 status,
  output logic [CW-1:0]                     ns,
  output logic [CW-1:0]                     ni,
  input  logic [CW-1:0]                     scan_idx,
  input  logic [nsvl_pkg::SLOT_W-1:0]       slot,
  input  logic signed [nsvl_pkg::FIELD_W-1:0] coord_x,
  input  logic signed [nsvl_pkg::FIELD_W-1:0] coord_y,
  input  logic signed [nsvl_pkg::FIELD_W-1:0] coord_z,
  input  logic [nsvl_pkg::SRC_W-1:0]        source_seed,
  input  logic                              cfg_valid,
  input  logic [nsvl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsvl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [nsvl_pkg::ID_W-1:0]         seed_id
);

  localparam int CB   = nsvl_pkg::COORD_BITS;
  localparam int PW   = 3 * CB;
  localparam int AWS  = (MAX_SEEDS  > 1) ? $clog2(MAX_SEEDS)  : 1;
  localparam int AWI  = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int DW   = nsvl_pkg::DIFF_W;
  localparam int SQW  = nsvl_pkg::SQ_W;
  localparam int DSW  = nsvl_pkg::DIST_W;

  // Configuration registers
  logic [nsvl_pkg::CNT_W-1:0] seed_count, image_count;
  logic                       periodic_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count    <= nsvl_pkg::CNT_W'(1);
      image_count   <= '0;
      periodic_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (nsvl_pkg::cfg_reg_t'(cfg_index))
        nsvl_pkg::REG_SEED_COUNT:  seed_count    <= cfg_data;
        nsvl_pkg::REG_IMAGE_COUNT: image_count   <= cfg_data;
        nsvl_pkg::REG_PERIODIC:    periodic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Counts saturated to store depths
  assign ns = (32'(seed_count)  > MAX_SEEDS)  ? CW'(MAX_SEEDS)  : CW'(seed_count);
  assign ni = (32'(image_count) > MAX_IMAGES) ? CW'(MAX_IMAGES) : CW'(image_count);

  // Seed stores: one write port, one registered read port each
  logic [PW-1:0]                 prim_mem [MAX_SEEDS];
  logic [PW-1:0]                 img_mem  [MAX_IMAGES];
  logic [nsvl_pkg::SRC_W-1:0]    src_mem  [MAX_IMAGES];
  logic [PW-1:0]                 prim_q, img_q;
  logic [nsvl_pkg::SRC_W-1:0]    src_q;
  logic [PW-1:0]                 load_pt;
  logic [CW-1:0]                 best_slot;

  assign load_pt = {coord_z[CB-1:0], coord_y[CB-1:0], coord_x[CB-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load_prim && (32'(slot) < MAX_SEEDS)) begin
      prim_mem[AWS'(slot)] <= load_pt;
    end
    if (cmd.rd_prim) begin
      prim_q <= prim_mem[scan_idx[AWS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_img && (32'(slot) < MAX_IMAGES)) begin
      img_mem[AWI'(slot)] <= load_pt;
    end
    if (cmd.rd_img) begin
      img_q <= img_mem[scan_idx[AWI-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_img && (32'(slot) < MAX_IMAGES)) begin
      src_mem[AWI'(slot)] <= source_seed;
    end
    if (cmd.rd_src) begin
      src_q <= src_mem[best_slot[AWI-1:0]];
    end
  end

  // Query point
  logic signed [CB-1:0] q_pt [3];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_pt[0] <= coord_x[CB-1:0];
      q_pt[1] <= coord_y[CB-1:0];
      q_pt[2] <= coord_z[CB-1:0];
    end
  end

  // Stage A: memory read data
  logic          a_valid, a_img;
  logic [CW-1:0] a_slot;
  logic [PW-1:0] a_coord;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= cmd.rd_prim || cmd.rd_img;
    a_img  <= cmd.rd_img;
    a_slot <= scan_idx;
  end

  assign a_coord = a_img ? img_q : prim_q;

  // Stage B: per-axis difference and square
  logic                 b_valid, b_img;
  logic [CW-1:0]        b_slot;
  logic [SQW-1:0]       b_sq [3];
  logic signed [DW-1:0]   diff [3];
  logic signed [2*DW-1:0] prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = DW'(q_pt[k]) - DW'($signed(a_coord[k*CB +: CB]));
      prod[k] = diff[k] * diff[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= a_valid;
    b_img  <= a_img;
    b_slot <= a_slot;
    for (int k = 0; k < 3; k++) begin
      b_sq[k] <= prod[k][SQW-1:0];
    end
  end

  // Stage C: sum and keep the first minimum
  logic [DSW-1:0] cand_d, best_d;
  logic           found, best_img;

  assign cand_d = DSW'(b_sq[0]) + DSW'(b_sq[1]) + DSW'(b_sq[2]);

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      found <= 1'b0;
    end else if (b_valid && (!found || (cand_d < best_d))) begin
      found <= 1'b1;
    end
    if (b_valid && (!found || (cand_d < best_d))) begin
      best_d    <= cand_d;
      best_img  <= b_img;
      best_slot <= b_slot;
    end
  end

  // Final id: primaries first, images after, periodic images map to their source
  logic [nsvl_pkg::ID_W-1:0] final_id;

  always_comb begin
    if (!found) begin
      final_id = '0;
    end else if (best_img && periodic_mode) begin
      final_id = nsvl_pkg::ID_W'(src_q);
    end else if (best_img) begin
      final_id = nsvl_pkg::ID_W'(32'(ns) + 32'(best_slot) + 32'd1);
    end else begin
      final_id = nsvl_pkg::ID_W'(32'(best_slot) + 32'd1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst)               m_tvalid <= 1'b0;
    else if (cmd.emit)     m_tvalid <= 1'b1;
    else if (m_tready)     m_tvalid <= 1'b0;
    if (cmd.emit) seed_id <= final_id;
  end

  assign status.pipe_busy = a_valid || b_valid;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

// ===== rtl/nearest_seed_voronoi_label_unit.sv =====
// Channel  Handshake                 Payload
// s        s_tvalid / s_tready       s_tdata: slot, coord_x, coord_y, coord_z, source_seed
//                                    s_tuser: opcode
// m        m_tvalid / m_tready       m_tdata: seed_id
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Loads are taken while idle and leave the unit ready. A query scans one seed
// distance per cycle through the shared three-stage distance pipeline, fed by
// a single read port per seed store, then drain, source lookup and result.
// Reset is synchronous; the seed stores are not cleared. A result waiting on
// m_tready holds the unit in its final state; loads still pass while idle.
// Top level: unpacks the buses and joins controller and datapath.
// Depends on nsvl_pkg, nsvl_ctrl, nsvl_datapath.
module nearest_seed_voronoi_label_unit #(
  parameter int MAX_SEEDS  = nsvl_pkg::MAX_SEEDS_DEF,
  parameter int MAX_IMAGES = nsvl_pkg::MAX_IMAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // slot[7:0], coord_x[23:8], coord_y[39:24], coord_z[55:40], source_seed[64:56]
  input  logic [nsvl_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode[1:0]
  input  logic [nsvl_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // seed_id[9:0]
  output logic [nsvl_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nsvl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsvl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int MAXD = (MAX_SEEDS > MAX_IMAGES) ? MAX_SEEDS : MAX_IMAGES;
  localparam int CW   = $clog2(MAXD + 1);

  nsvl_pkg::cmd_t            cmd;
  nsvl_pkg::status_t         status;
  logic [CW-1:0]             ns, ni, scan_idx;
  logic [nsvl_pkg::ID_W-1:0] seed_id;

  // Config writes are always taken
  assign cfg_ready = 1'b1;
  assign m_tdata   = nsvl_pkg::OUT_DATA_W'(seed_id);

  nsvl_ctrl #(
    .CW (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (nsvl_pkg::op_t'(s_tuser)),
    .s_tready (s_tready),
    .ns       (ns),
    .ni       (ni),
    .status   (status),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  nsvl_datapath #(
    .MAX_SEEDS  (MAX_SEEDS),
    .MAX_IMAGES (MAX_IMAGES),
    .CW         (CW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .ns          (ns),
    .ni          (ni),
    .scan_idx    (scan_idx),
    .slot        (s_tdata[nsvl_pkg::SLOT_LSB +: nsvl_pkg::SLOT_W]),
    .coord_x     (s_tdata[nsvl_pkg::X_LSB +: nsvl_pkg::FIELD_W]),
    .coord_y     (s_tdata[nsvl_pkg::Y_LSB +: nsvl_pkg::FIELD_W]),
    .coord_z     (s_tdata[nsvl_pkg::Z_LSB +: nsvl_pkg::FIELD_W]),
    .source_seed (s_tdata[nsvl_pkg::SRC_LSB +: nsvl_pkg::SRC_W]),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .seed_id     (seed_id)
  );

endmodule

// ===== rtl/nsvl_checker.sv =====
// Port-level checks for the nearest-seed label unit, bound to the top level.
// Depends on nsvl_pkg and nearest_seed_voronoi_label_unit.
module nsvl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [nsvl_pkg::IN_USER_W-1:0]    s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [nsvl_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A query takes the unit off the input
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == nsvl_pkg::OP_QUERY) |=> !s_tready)
    else $error("input ready right after a query item");

  // Loads leave the unit ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    ((s_tuser == nsvl_pkg::OP_LOAD_PRIM) || (s_tuser == nsvl_pkg::OP_LOAD_IMG))
    |=> s_tready)
    else $error("input not ready after a load item");

  // A new result only comes out of a query in progress
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

endmodule

bind nearest_seed_voronoi_label_unit nsvl_checker u_nsvl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/nsvl_label_checker.sv =====
`timescale 1ns / 100ps
// Checker for the nearest-seed Voronoi label unit: watches the load/query,
// result and register channels, predicts each seed_id and compares in order.
// Depends on nsvl_pkg for bus widths, field positions, opcodes and registers.
module nsvl_label_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [nsvl_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [nsvl_pkg::IN_USER_W-1:0]    s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [nsvl_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [nsvl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsvl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                mismatch_count,
  output int                                ids_pending
);
  import nsvl_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
  } point_t;

  // Shadow copy of the seed stores and registers
  point_t             prim_pts [MAX_SEEDS_DEF];
  point_t             img_pts  [MAX_IMAGES_DEF];
  logic [SRC_W-1:0]   img_src  [MAX_IMAGES_DEF];
  logic [CNT_W-1:0]   seed_cnt;
  logic [CNT_W-1:0]   img_cnt;
  logic               periodic;

  logic [ID_W-1:0]    expected_ids [$];
  int                 mism = 0;

  function automatic logic [DIST_W-1:0] sq_dist(point_t a, point_t b);
    longint dx, dy, dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Brute-force scan: primaries then images, first minimum wins
  function automatic logic [ID_W-1:0] nearest_seed(point_t q);
    int                ns, ni, best;
    logic [DIST_W-1:0] best_d, d;
    bit                found;
    ns     = (seed_cnt > MAX_SEEDS_DEF) ? MAX_SEEDS_DEF : int'(seed_cnt);
    ni     = (img_cnt > MAX_IMAGES_DEF) ? MAX_IMAGES_DEF : int'(img_cnt);
    found  = 1'b0;
    best   = 0;
    best_d = '0;
    for (int i = 0; i < ns; i++) begin
      d = sq_dist(q, prim_pts[i]);
      if (!found || d < best_d) begin
        found  = 1'b1;
        best_d = d;
        best   = i + 1;
      end
    end
    for (int i = 0; i < ni; i++) begin
      d = sq_dist(q, img_pts[i]);
      if (!found || d < best_d) begin
        found  = 1'b1;
        best_d = d;
        best   = ns + i + 1;
      end
    end
    // periodic mode folds a winning image back onto its source seed
    if (found && periodic && best > ns) best = int'(img_src[best - ns - 1]);
    return ID_W'(best);
  endfunction

  task automatic report(string what, int want, logic [OUT_DATA_W-1:0] got);
    if (mism < 10) $display("%t seed_id %s: expected %0d actual %0d", $realtime, what, want, got);
    mism++;
  endtask

  always @(posedge clk) begin
    logic [ID_W-1:0]   want;
    logic [SLOT_W-1:0] slot;
    point_t            pt;
    if (rst) begin
      seed_cnt = CNT_W'(1);
      img_cnt  = '0;
      periodic = 1'b0;
      expected_ids.delete();
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_ids.size() == 0) begin
          report("unexpected", -1, m_tdata);
        end else begin
          want = expected_ids.pop_front();
          if (m_tdata !== OUT_DATA_W'(want)) report("mismatch", int'(want), m_tdata);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEED_COUNT:  seed_cnt = cfg_data;
          REG_IMAGE_COUNT: img_cnt  = cfg_data;
          REG_PERIODIC:    periodic = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        slot = s_tdata[SLOT_LSB +: SLOT_W];
        pt.x = s_tdata[X_LSB +: FIELD_W];
        pt.y = s_tdata[Y_LSB +: FIELD_W];
        pt.z = s_tdata[Z_LSB +: FIELD_W];
        case (s_tuser)
          OP_LOAD_PRIM: prim_pts[slot] = pt;
          OP_LOAD_IMG: begin
            img_pts[slot] = pt;
            img_src[slot] = s_tdata[SRC_LSB +: SRC_W];
          end
          OP_QUERY: expected_ids.push_back(nearest_seed(pt));
          default: ;
        endcase
      end
    end
    ids_pending    <= expected_ids.size();
    mismatch_count <= mism;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the label unit testbench: clock, reset, load/query stimulus, random
// result back-pressure and the verdict. Depends on nsvl_pkg, the label unit
// and nsvl_label_checker, which does all prediction and comparison.
module testbench;
  import nsvl_pkg::*;

  localparam int          RANDOM_ITEMS  = 580;
  localparam int          CALM_TAIL     = 200;      // last items run without idling
  localparam int          SETTLE_CYCLES = 16;
  localparam int          DRAIN_CYCLES  = 64;
  localparam int          HOLD_CYCLES   = 2000;
  localparam int          LIMIT_CYCLES  = 6000000;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic [IN_USER_W-1:0]    s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  int                      mismatch_count;
  int                      ids_pending;
  int                      cycles = 0;
  int                      random_sent = 0;
  int                      holds_asked = 0;
  int                      holds_done = 0;
  bit                      idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_seed_voronoi_label_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nsvl_label_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .ids_pending    (ids_pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Coordinates: full range, a tiny cluster around zero (ties), or extremes
  function automatic logic [FIELD_W-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 3))
      1: begin
        v = int'($urandom_range(0, 8)) - 4;
        return v[FIELD_W-1:0];
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h8001;
          default: return 16'h0000;
        endcase
      end
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  // One item on the load/query stream, with an optional idle burst first
  task automatic send_item(logic [1:0] op, logic [SLOT_W-1:0] slot, logic [FIELD_W-1:0] x,
                           logic [FIELD_W-1:0] y, logic [FIELD_W-1:0] z,
                           logic [SRC_W-1:0] src);
    logic [IN_DATA_W-1:0] word;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    word                        = '0;
    word[SLOT_LSB +: SLOT_W]    = slot;
    word[X_LSB +: FIELD_W]      = x;
    word[Y_LSB +: FIELD_W]      = y;
    word[Z_LSB +: FIELD_W]      = z;
    word[SRC_LSB +: SRC_W]      = src;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      send_item(OP_QUERY, SLOT_W'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                SRC_W'($urandom()));
    else if (r < 80)
      send_item(OP_LOAD_PRIM, SLOT_W'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                SRC_W'($urandom()));
    else if (r < 95)
      send_item(OP_LOAD_IMG, SLOT_W'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                SRC_W'($urandom()));
    else
      send_item(OP_UNUSED, SLOT_W'($urandom()), FIELD_W'($urandom()), FIELD_W'($urandom()),
                FIELD_W'($urandom()), SRC_W'($urandom()));
    if (r < 95) random_sent++;
  endtask

  // Wait until every query has its result and the unit has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ids_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [CNT_W-1:0] sc, logic [CNT_W-1:0] ic, logic per);
    cfg_write(REG_SEED_COUNT, sc);
    cfg_write(REG_IMAGE_COUNT, ic);
    cfg_write(REG_PERIODIC, CFG_DATA_W'(per));
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Result side: random ready bursts, one long hold-off on request
  initial begin : result_sink
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_asked > holds_done) begin
        m_tready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        holds_done++;
      end else if (!idle_on) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          phase, batch, r;
    logic [CNT_W-1:0] sc, ic;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset counts (one primary), extreme distance, ignored fields
    send_item(OP_LOAD_PRIM, 8'd0, 16'h8000, 16'h8000, 16'h8000, 9'h1FF);
    send_item(OP_QUERY, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 9'h1FF);
    send_item(OP_QUERY, 8'hA5, 16'h8000, 16'h8000, 16'h8000, 9'h0AA);
    send_item(OP_UNUSED, 8'h5A, 16'h1234, 16'hFEDC, 16'h7FFF, 9'h155);
    // no seeds at all gives id 0
    settle();
    configure(9'd0, 9'd0, 1'b0);
    send_item(OP_QUERY, 8'd0, 16'h0000, 16'h0000, 16'h0000, 9'd0);
    // duplicate points for ties, image copying a primary, top slots
    send_item(OP_LOAD_PRIM, 8'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 9'd0);
    send_item(OP_LOAD_PRIM, 8'd2, 16'h0000, 16'h0000, 16'h0000, 9'd0);
    send_item(OP_LOAD_PRIM, 8'd3, 16'h0000, 16'h0000, 16'h0000, 9'd0);
    send_item(OP_LOAD_PRIM, 8'd255, 16'h0001, 16'h0001, 16'h0001, 9'd0);
    send_item(OP_LOAD_IMG, 8'd0, 16'h0005, 16'h0005, 16'h0005, 9'd3);
    send_item(OP_LOAD_IMG, 8'd1, 16'h0000, 16'h0000, 16'h0000, 9'd2);
    send_item(OP_LOAD_IMG, 8'd255, 16'hFFFB, 16'hFFFB, 16'hFFFB, 9'h1FF);
    settle();
    configure(9'd4, 9'd2, 1'b1);
    send_item(OP_QUERY, 8'd0, 16'h0000, 16'h0000, 16'h0000, 9'd0);
    send_item(OP_QUERY, 8'd0, 16'h0004, 16'h0005, 16'h0005, 9'd0);
    send_item(OP_QUERY, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFE, 9'd0);
    settle();
    configure(9'd4, 9'd2, 1'b0);
    send_item(OP_QUERY, 8'd0, 16'h0005, 16'h0005, 16'h0005, 9'd0);
    // images only
    settle();
    configure(9'd0, 9'd2, 1'b1);
    send_item(OP_QUERY, 8'd0, 16'h0005, 16'h0005, 16'h0005, 9'd0);
    send_item(OP_QUERY, 8'd0, 16'h0001, 16'h0001, 16'h0001, 9'd0);

    // Fill both stores so any count can be queried from here on
    for (int i = 0; i < MAX_SEEDS_DEF; i++)
      send_item(OP_LOAD_PRIM, SLOT_W'(i), rand_coord(), rand_coord(), rand_coord(),
                SRC_W'($urandom()));
    for (int i = 0; i < MAX_IMAGES_DEF; i++)
      send_item(OP_LOAD_IMG, SLOT_W'(i), rand_coord(), rand_coord(), rand_coord(),
                SRC_W'($urandom()));

    // Random phases: new register settings, then a burst of mixed items
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(0, 9);
      case (r)
        0: begin
          sc = '0;
          ic = CNT_W'($urandom_range(0, 16));
        end
        1: begin
          sc = CNT_W'(MAX_SEEDS_DEF);
          ic = CNT_W'(MAX_IMAGES_DEF);
        end
        2: begin
          sc = CNT_W'($urandom_range(MAX_SEEDS_DEF + 1, 511));
          ic = CNT_W'($urandom_range(MAX_IMAGES_DEF + 1, 511));
        end
        3: begin
          sc = CNT_W'($urandom());
          ic = CNT_W'($urandom());
        end
        default: begin
          sc = CNT_W'($urandom_range(1, 16));
          ic = CNT_W'($urandom_range(0, 16));
        end
      endcase
      configure(sc, ic, $urandom_range(0, 1) != 0);
      // one long result stall while queries keep coming
      if (phase == 3) begin
        holds_asked++;
        batch = 30;
      end else begin
        batch = $urandom_range(8, 40);
      end
      repeat (batch) send_random();
      if (random_sent > RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      phase++;
    end

    // Drain and verdict
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ids_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && ids_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
